FILE: sv/bgi_pkg.sv
package bgi_pkg;

    // Grid geometry and fixed-point format
    localparam int GRID_X    = 16;
    localparam int GRID_Y    = 16;
    localparam int FRAC_BITS = 16;
    localparam int ONE       = 1 << FRAC_BITS;

    // Field and datapath widths
    localparam int D_W     = 32;                  // samples, coordinates, result
    localparam int IDX_W   = 4;                   // column / row index
    localparam int CNT_W   = 5;                   // points-used registers
    localparam int PROD_W  = 2 * D_W;             // |d| * recip
    localparam int FR_W    = FRAC_BITS + 1;       // signed fraction
    localparam int OM_W    = FRAC_BITS + 2;       // one minus fraction
    localparam int PW_W    = 2 * OM_W;            // raw weight product
    localparam int W_W     = 20;                  // weight field
    localparam int MUL_W   = W_W + D_W;           // weight * sample
    localparam int ACC_W   = MUL_W + 2;           // sum of four terms

    // Sample store: four banks split by column and row parity
    localparam int NUM_BANKS = 4;
    localparam int BANK_AW   = 2 * (IDX_W - 1);

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP_RECIP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP_RECIP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_POINTS_USED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_POINTS_USED = 3'd5;

    typedef struct packed {
        logic                     command;
        logic [IDX_W-1:0]         load_col;
        logic [IDX_W-1:0]         load_row;
        logic signed [D_W-1:0]    load_value;
        logic signed [D_W-1:0]    query_x;
        logic signed [D_W-1:0]    query_y;
    } t_in_item;

    typedef struct packed {
        logic signed [D_W-1:0]    blended;
        logic                     inside_res;
        logic signed [W_W-1:0]    weight_00;
        logic signed [W_W-1:0]    weight_10;
        logic signed [W_W-1:0]    weight_01;
        logic signed [W_W-1:0]    weight_11;
    } t_out_item;

    typedef struct packed {
        logic signed [D_W-1:0]    x_origin;
        logic signed [D_W-1:0]    y_origin;
        logic [D_W-1:0]           x_step_recip;
        logic [D_W-1:0]           y_step_recip;
        logic [CNT_W-1:0]         x_points_used;
        logic [CNT_W-1:0]         y_points_used;
    } t_cfg;

    // Classified item handed from front to back
    typedef struct packed {
        logic                     is_query;
        logic [IDX_W-1:0]         col;
        logic [IDX_W-1:0]         row;
        logic signed [D_W-1:0]    value;
        logic                     in_grid;
        logic [IDX_W-1:0]         ix;
        logic [IDX_W-1:0]         iy;
        logic signed [FR_W-1:0]   xr;
        logic signed [FR_W-1:0]   yr;
        logic                     cx;
        logic                     cy;
    } t_job;

endpackage

FILE: sv/bgi_ram.sv
module bgi_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; hold data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/bgi_front.sv
module bgi_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bgi_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bgi_pkg::t_in_item i_in_item,
    output logic              o_push,
    output bgi_pkg::t_job     o_job,
    input  logic              i_full
);

    typedef struct packed {
        logic                                 in_grid;
        logic [bgi_pkg::IDX_W-1:0]            pos;
        logic signed [bgi_pkg::FR_W-1:0]      frac;
        logic                                 cont;
    } t_axis;

    // Locate one axis from the sign and the scaled magnitude
    function automatic t_axis locate(
        input logic                          neg,
        input logic [bgi_pkg::PROD_W-1:0]    prod,
        input logic [bgi_pkg::CNT_W-1:0]     used,
        input logic [bgi_pkg::CNT_W-1:0]     lim
    );
        t_axis                                           a;
        logic [bgi_pkg::PROD_W-2*bgi_pkg::FRAC_BITS-1:0] idx;
        logic [bgi_pkg::FRAC_BITS-1:0]                   fr;
        logic [bgi_pkg::CNT_W-1:0]                       n;
        idx = prod[bgi_pkg::PROD_W-1:2*bgi_pkg::FRAC_BITS];
        fr  = prod[2*bgi_pkg::FRAC_BITS-1:bgi_pkg::FRAC_BITS];
        n   = (used > lim) ? lim : used;
        a.in_grid = !(neg && (idx != '0))
                 && (idx < ($bits(idx))'(n));
        a.pos  = idx[bgi_pkg::IDX_W-1:0];
        a.frac = neg ? -$signed({1'b0, fr}) : $signed({1'b0, fr});
        a.cont = ((bgi_pkg::CNT_W)'(idx[bgi_pkg::IDX_W-1:0]) + 1'b1) < n;
        return a;
    endfunction

    logic                               r_f1_valid;
    logic                               r_f1_query;
    logic [bgi_pkg::IDX_W-1:0]          r_f1_col;
    logic [bgi_pkg::IDX_W-1:0]          r_f1_row;
    logic signed [bgi_pkg::D_W-1:0]     r_f1_value;
    logic                               r_f1_negx;
    logic                               r_f1_negy;
    logic [bgi_pkg::D_W-1:0]            r_f1_magx;
    logic [bgi_pkg::D_W-1:0]            r_f1_magy;

    logic                               r_f2_valid;
    logic                               r_f2_query;
    logic [bgi_pkg::IDX_W-1:0]          r_f2_col;
    logic [bgi_pkg::IDX_W-1:0]          r_f2_row;
    logic signed [bgi_pkg::D_W-1:0]     r_f2_value;
    logic                               r_f2_negx;
    logic                               r_f2_negy;
    logic [bgi_pkg::PROD_W-1:0]         r_f2_prodx;
    logic [bgi_pkg::PROD_W-1:0]         r_f2_prody;

    logic signed [bgi_pkg::D_W:0]       dx;
    logic signed [bgi_pkg::D_W:0]       dy;
    logic signed [bgi_pkg::D_W:0]       ndx;
    logic signed [bgi_pkg::D_W:0]       ndy;
    logic                               f1_ready;
    logic                               f2_ready;
    t_axis                              ax;
    t_axis                              ay;

    // Stall chain from the queue back to the input
    assign f2_ready   = !r_f2_valid || !i_full;
    assign f1_ready   = !r_f1_valid || f2_ready;
    assign o_in_ready = f1_ready;
    assign o_push     = r_f2_valid && !i_full;

    // Offset from the grid start and its magnitude
    assign dx  = (bgi_pkg::D_W + 1)'(i_in_item.query_x) - (bgi_pkg::D_W + 1)'(i_cfg.x_origin);
    assign dy  = (bgi_pkg::D_W + 1)'(i_in_item.query_y) - (bgi_pkg::D_W + 1)'(i_cfg.y_origin);
    assign ndx = -dx;
    assign ndy = -dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            if (f1_ready) begin
                r_f1_valid <= i_in_valid;
            end
            if (f2_ready) begin
                r_f2_valid <= r_f1_valid;
            end
        end
    end

    // Capture the item and the offset magnitudes
    always_ff @(posedge i_clk) begin
        if (i_in_valid && f1_ready) begin
            r_f1_query <= (i_in_item.command == bgi_pkg::CMD_QUERY);
            r_f1_col   <= i_in_item.load_col;
            r_f1_row   <= i_in_item.load_row;
            r_f1_value <= i_in_item.load_value;
            r_f1_negx  <= dx[bgi_pkg::D_W];
            r_f1_negy  <= dy[bgi_pkg::D_W];
            r_f1_magx  <= dx[bgi_pkg::D_W] ? ndx[bgi_pkg::D_W-1:0] : dx[bgi_pkg::D_W-1:0];
            r_f1_magy  <= dy[bgi_pkg::D_W] ? ndy[bgi_pkg::D_W-1:0] : dy[bgi_pkg::D_W-1:0];
        end
    end

    // Scale by the step reciprocals
    always_ff @(posedge i_clk) begin
        if (r_f1_valid && f2_ready) begin
            r_f2_query <= r_f1_query;
            r_f2_col   <= r_f1_col;
            r_f2_row   <= r_f1_row;
            r_f2_value <= r_f1_value;
            r_f2_negx  <= r_f1_negx;
            r_f2_negy  <= r_f1_negy;
            r_f2_prodx <= (bgi_pkg::PROD_W)'(r_f1_magx)
                        * (bgi_pkg::PROD_W)'(i_cfg.x_step_recip);
            r_f2_prody <= (bgi_pkg::PROD_W)'(r_f1_magy)
                        * (bgi_pkg::PROD_W)'(i_cfg.y_step_recip);
        end
    end

    // Classify: cell, fraction, in-grid and edge flags
    assign ax = locate(r_f2_negx, r_f2_prodx, i_cfg.x_points_used,
                       (bgi_pkg::CNT_W)'(bgi_pkg::GRID_X));
    assign ay = locate(r_f2_negy, r_f2_prody, i_cfg.y_points_used,
                       (bgi_pkg::CNT_W)'(bgi_pkg::GRID_Y));

    always_comb begin
        o_job.is_query = r_f2_query;
        o_job.col      = r_f2_col;
        o_job.row      = r_f2_row;
        o_job.value    = r_f2_value;
        o_job.in_grid  = ax.in_grid && ay.in_grid;
        o_job.ix       = ax.pos;
        o_job.iy       = ay.pos;
        o_job.xr       = ax.frac;
        o_job.yr       = ay.frac;
        o_job.cx       = ax.cont;
        o_job.cy       = ay.cont;
    end

endmodule

FILE: sv/bgi_queue.sv
module bgi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bgi_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output bgi_pkg::t_job o_head
);

    bgi_pkg::t_job               r_mem [bgi_pkg::QUEUE_DEPTH];
    logic [bgi_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [bgi_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [bgi_pkg::QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == (bgi_pkg::QCNT_W)'(bgi_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: sv/bgi_back.sv
module bgi_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  bgi_pkg::t_job      i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bgi_pkg::t_out_item o_out_item
);

    localparam logic signed [bgi_pkg::OM_W-1:0] ONE_OM = (bgi_pkg::OM_W)'(bgi_pkg::ONE);
    localparam logic signed [bgi_pkg::W_W-1:0]  ONE_W  = (bgi_pkg::W_W)'(bgi_pkg::ONE);
    localparam int                              HI_W   = bgi_pkg::ACC_W - bgi_pkg::D_W + 1;

    logic signed [bgi_pkg::D_W-1:0]    bank_data [bgi_pkg::NUM_BANKS];

    // Stage 1: raw weight products and sample reads
    logic                              r_b1_valid;
    logic                              r_b1_inside;
    logic                              r_b1_cx;
    logic                              r_b1_cy;
    logic                              r_b1_ixp;
    logic                              r_b1_iyp;
    logic signed [bgi_pkg::FR_W-1:0]   r_b1_xr;
    logic signed [bgi_pkg::FR_W-1:0]   r_b1_yr;
    logic signed [bgi_pkg::PW_W-1:0]   r_b1_p00;
    logic signed [bgi_pkg::PW_W-1:0]   r_b1_p10;
    logic signed [bgi_pkg::PW_W-1:0]   r_b1_p01;
    logic signed [bgi_pkg::PW_W-1:0]   r_b1_p11;

    // Stage 2: final weights and weighted samples
    logic                              r_b2_valid;
    logic                              r_b2_inside;
    logic signed [bgi_pkg::W_W-1:0]    r_b2_w00;
    logic signed [bgi_pkg::W_W-1:0]    r_b2_w10;
    logic signed [bgi_pkg::W_W-1:0]    r_b2_w01;
    logic signed [bgi_pkg::W_W-1:0]    r_b2_w11;
    logic signed [bgi_pkg::MUL_W-1:0]  r_b2_m00;
    logic signed [bgi_pkg::MUL_W-1:0]  r_b2_m10;
    logic signed [bgi_pkg::MUL_W-1:0]  r_b2_m01;
    logic signed [bgi_pkg::MUL_W-1:0]  r_b2_m11;

    // Output register
    logic                              r_out_valid;
    bgi_pkg::t_out_item                r_out_item;

    logic                              out_free;
    logic                              b2_free;
    logic                              b1_free;
    logic                              is_load;
    logic                              is_read;
    logic signed [bgi_pkg::OM_W-1:0]   h_xr;
    logic signed [bgi_pkg::OM_W-1:0]   h_yr;
    logic signed [bgi_pkg::OM_W-1:0]   h_omx;
    logic signed [bgi_pkg::OM_W-1:0]   h_omy;
    logic signed [bgi_pkg::OM_W-1:0]   b1_xr;
    logic signed [bgi_pkg::OM_W-1:0]   b1_yr;
    logic signed [bgi_pkg::OM_W-1:0]   b1_omx;
    logic signed [bgi_pkg::OM_W-1:0]   b1_omy;
    logic signed [bgi_pkg::PW_W-1:0]   sh00;
    logic signed [bgi_pkg::PW_W-1:0]   sh10;
    logic signed [bgi_pkg::PW_W-1:0]   sh01;
    logic signed [bgi_pkg::PW_W-1:0]   sh11;
    logic signed [bgi_pkg::W_W-1:0]    w00;
    logic signed [bgi_pkg::W_W-1:0]    w10;
    logic signed [bgi_pkg::W_W-1:0]    w01;
    logic signed [bgi_pkg::W_W-1:0]    w11;
    logic signed [bgi_pkg::D_W-1:0]    s00;
    logic signed [bgi_pkg::D_W-1:0]    s10;
    logic signed [bgi_pkg::D_W-1:0]    s01;
    logic signed [bgi_pkg::D_W-1:0]    s11;
    logic signed [bgi_pkg::ACC_W-1:0]  acc;
    logic signed [bgi_pkg::ACC_W-1:0]  acc_sh;
    logic [HI_W-1:0]                   acc_hi;
    logic signed [bgi_pkg::D_W-1:0]    blend;

    // Stall chain from the output register back to the queue
    assign out_free = !r_out_valid || i_out_ready;
    assign b2_free  = !r_b2_valid || out_free;
    assign b1_free  = !r_b1_valid || b2_free;
    assign is_load  = !i_head.is_query;
    assign o_pop    = i_head_valid && (is_load || b1_free);
    assign is_read  = o_pop && i_head.is_query;

    // Sample store banks, one per column/row parity
    for (genvar k = 0; k < bgi_pkg::NUM_BANKS; k++) begin : g_bank
        localparam logic [1:0] KB = 2'(k);
        logic                          we;
        logic [bgi_pkg::IDX_W-1:0]     rcol;
        logic [bgi_pkg::IDX_W-1:0]     rrow;
        logic [bgi_pkg::D_W-1:0]       rdata;

        assign we   = o_pop && is_load && ({i_head.col[0], i_head.row[0]} == KB);
        assign rcol = (i_head.ix[0] == KB[1]) ? i_head.ix : i_head.ix + 1'b1;
        assign rrow = (i_head.iy[0] == KB[0]) ? i_head.iy : i_head.iy + 1'b1;

        bgi_ram #(
            .ADDR_W (bgi_pkg::BANK_AW),
            .DATA_W (bgi_pkg::D_W)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr ({i_head.col[bgi_pkg::IDX_W-1:1], i_head.row[bgi_pkg::IDX_W-1:1]}),
            .i_wdata (i_head.value),
            .i_re    (is_read),
            .i_raddr ({rcol[bgi_pkg::IDX_W-1:1], rrow[bgi_pkg::IDX_W-1:1]}),
            .o_rdata (rdata)
        );

        assign bank_data[k] = $signed(rdata);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (b1_free) begin
                r_b1_valid <= is_read;
            end
            if (b2_free) begin
                r_b2_valid <= r_b1_valid;
            end
            if (out_free) begin
                r_out_valid <= r_b2_valid;
            end
        end
    end

    // Stage 1: form one-minus-fraction and the bilinear products
    assign h_xr  = (bgi_pkg::OM_W)'(i_head.xr);
    assign h_yr  = (bgi_pkg::OM_W)'(i_head.yr);
    assign h_omx = ONE_OM - h_xr;
    assign h_omy = ONE_OM - h_yr;

    always_ff @(posedge i_clk) begin
        if (is_read) begin
            r_b1_inside <= i_head.in_grid;
            r_b1_cx     <= i_head.cx;
            r_b1_cy     <= i_head.cy;
            r_b1_ixp    <= i_head.ix[0];
            r_b1_iyp    <= i_head.iy[0];
            r_b1_xr     <= i_head.xr;
            r_b1_yr     <= i_head.yr;
            r_b1_p00    <= (bgi_pkg::PW_W)'(h_omx) * (bgi_pkg::PW_W)'(h_omy);
            r_b1_p10    <= (bgi_pkg::PW_W)'(h_xr)  * (bgi_pkg::PW_W)'(h_omy);
            r_b1_p01    <= (bgi_pkg::PW_W)'(h_omx) * (bgi_pkg::PW_W)'(h_yr);
            r_b1_p11    <= (bgi_pkg::PW_W)'(h_xr)  * (bgi_pkg::PW_W)'(h_yr);
        end
    end

    // Stage 2: pick weights for interior, edge and corner cells; all zero outside
    assign b1_xr  = (bgi_pkg::OM_W)'(r_b1_xr);
    assign b1_yr  = (bgi_pkg::OM_W)'(r_b1_yr);
    assign b1_omx = ONE_OM - b1_xr;
    assign b1_omy = ONE_OM - b1_yr;
    assign sh00   = r_b1_p00 >>> bgi_pkg::FRAC_BITS;
    assign sh10   = r_b1_p10 >>> bgi_pkg::FRAC_BITS;
    assign sh01   = r_b1_p01 >>> bgi_pkg::FRAC_BITS;
    assign sh11   = r_b1_p11 >>> bgi_pkg::FRAC_BITS;

    always_comb begin
        w00 = '0;
        w10 = '0;
        w01 = '0;
        w11 = '0;
        if (!r_b1_inside) begin
            w00 = '0;
        end else if (r_b1_cx && r_b1_cy) begin
            w00 = sh00[bgi_pkg::W_W-1:0];
            w10 = sh10[bgi_pkg::W_W-1:0];
            w01 = sh01[bgi_pkg::W_W-1:0];
            w11 = sh11[bgi_pkg::W_W-1:0];
        end else if (!r_b1_cx && !r_b1_cy) begin
            w00 = ONE_W;
        end else if (!r_b1_cx) begin
            w00 = (bgi_pkg::W_W)'(b1_omy);
            w01 = (bgi_pkg::W_W)'(b1_yr);
        end else begin
            w00 = (bgi_pkg::W_W)'(b1_omx);
            w10 = (bgi_pkg::W_W)'(b1_xr);
        end
    end

    // Route bank outputs to the four neighbors
    assign s00 = bank_data[{r_b1_ixp,  r_b1_iyp}];
    assign s10 = bank_data[{!r_b1_ixp, r_b1_iyp}];
    assign s01 = bank_data[{r_b1_ixp,  !r_b1_iyp}];
    assign s11 = bank_data[{!r_b1_ixp, !r_b1_iyp}];

    // Weight the samples; drop neighbors that do not exist
    always_ff @(posedge i_clk) begin
        if (r_b1_valid && b2_free) begin
            r_b2_inside <= r_b1_inside;
            r_b2_w00    <= w00;
            r_b2_w10    <= w10;
            r_b2_w01    <= w01;
            r_b2_w11    <= w11;
            r_b2_m00    <= r_b1_inside
                         ? (bgi_pkg::MUL_W)'(w00) * (bgi_pkg::MUL_W)'(s00) : '0;
            r_b2_m10    <= (r_b1_inside && r_b1_cx)
                         ? (bgi_pkg::MUL_W)'(w10) * (bgi_pkg::MUL_W)'(s10) : '0;
            r_b2_m01    <= (r_b1_inside && r_b1_cy)
                         ? (bgi_pkg::MUL_W)'(w01) * (bgi_pkg::MUL_W)'(s01) : '0;
            r_b2_m11    <= (r_b1_inside && r_b1_cx && r_b1_cy)
                         ? (bgi_pkg::MUL_W)'(w11) * (bgi_pkg::MUL_W)'(s11) : '0;
        end
    end

    // Sum, scale down and saturate
    assign acc    = (bgi_pkg::ACC_W)'(r_b2_m00) + (bgi_pkg::ACC_W)'(r_b2_m10)
                  + (bgi_pkg::ACC_W)'(r_b2_m01) + (bgi_pkg::ACC_W)'(r_b2_m11);
    assign acc_sh = acc >>> bgi_pkg::FRAC_BITS;
    assign acc_hi = acc_sh[bgi_pkg::ACC_W-1:bgi_pkg::D_W-1];

    always_comb begin
        if ((acc_hi == '0) || (acc_hi == '1)) begin
            blend = acc_sh[bgi_pkg::D_W-1:0];
        end else if (acc_sh[bgi_pkg::ACC_W-1]) begin
            blend = {1'b1, {(bgi_pkg::D_W-1){1'b0}}};
        end else begin
            blend = {1'b0, {(bgi_pkg::D_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b2_valid && out_free) begin
            r_out_item.blended    <= blend;
            r_out_item.inside_res <= r_b2_inside;
            r_out_item.weight_00  <= r_b2_w00;
            r_out_item.weight_10  <= r_b2_w10;
            r_out_item.weight_01  <= r_b2_w01;
            r_out_item.weight_11  <= r_b2_w11;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: sv/bilinear_grid_interpolator.sv
// Bilinear interpolator over a 16 x 16 grid of signed Q16.16 samples. A load
// item writes one sample; a query item returns the blend of the four
// surrounding samples and the four weights, or all zeros when the point lies
// outside the used grid. Samples must be loaded before any query touches them.
// Items are taken one per cycle while the job queue has room: the front end
// (offset, 32 x 32 scale by the step reciprocal, cell classification) feeds a
// four-entry job queue, and the back end reads all four neighbors in the same
// cycle from four sample banks split by column and row parity, then forms
// weights, products and the saturated sum. Queries pass the front stages, the
// queue, the back-end stages and the output register; loads produce no result.
// Write the configuration registers only while no item is in flight.
module bilinear_grid_interpolator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bgi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bgi_pkg::D_W-1:0]           i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bgi_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bgi_pkg::t_out_item                o_out_item
);

    bgi_pkg::t_cfg  r_cfg;
    bgi_pkg::t_job  front_job;
    bgi_pkg::t_job  head_job;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_origin      <= '0;
            r_cfg.y_origin      <= '0;
            r_cfg.x_step_recip  <= (bgi_pkg::D_W)'(bgi_pkg::ONE);
            r_cfg.y_step_recip  <= (bgi_pkg::D_W)'(bgi_pkg::ONE);
            r_cfg.x_points_used <= (bgi_pkg::CNT_W)'(bgi_pkg::GRID_X);
            r_cfg.y_points_used <= (bgi_pkg::CNT_W)'(bgi_pkg::GRID_Y);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bgi_pkg::CFG_X_ORIGIN:      r_cfg.x_origin      <= $signed(i_cfg_data);
                bgi_pkg::CFG_Y_ORIGIN:      r_cfg.y_origin      <= $signed(i_cfg_data);
                bgi_pkg::CFG_X_STEP_RECIP:  r_cfg.x_step_recip  <= i_cfg_data;
                bgi_pkg::CFG_Y_STEP_RECIP:  r_cfg.y_step_recip  <= i_cfg_data;
                bgi_pkg::CFG_X_POINTS_USED:
                    r_cfg.x_points_used <= i_cfg_data[bgi_pkg::CNT_W-1:0];
                bgi_pkg::CFG_Y_POINTS_USED:
                    r_cfg.y_points_used <= i_cfg_data[bgi_pkg::CNT_W-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    bgi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_push     (push),
        .o_job      (front_job),
        .i_full     (q_full)
    );

    bgi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_job)
    );

    bgi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (head_job),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule
